FILE: rtl/lpkc_pkg.sv
// ----------------------------------------------------------------------------
// lpkc_pkg
// Shared types and constants for the path key cache: request and response
// payloads and the width of a stored key.
// ----------------------------------------------------------------------------
package lpkc_pkg;

   localparam int KIND_W = 4;
   localparam int RULE_W = 2;
   localparam int HASH_W = 64;
   localparam int KEY_W  = KIND_W + RULE_W + HASH_W;
   localparam int SLOT_W = 6;

   typedef struct packed {
      logic [KIND_W-1:0] shape_kind;
      logic [RULE_W-1:0] fill_rule;
      logic [HASH_W-1:0] content_hash;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
      logic              evicted;
   } rsp_type;

endpackage

FILE: rtl/lru_path_key_cache.sv
// ----------------------------------------------------------------------------
// lru_path_key_cache
// Fully associative least-recently-used key store with one response per request.
// ----------------------------------------------------------------------------
// A miss passes through the search sweep, the age sweep, the fill step and
// the response step; a hit skips the fill step, and a request on an empty
// store goes straight to the fill step. With N occupied slots, the search
// and the age sweep each read one slot per cycle over those N slots.
// Throughput: one request at a time, taken the cycle after the response is
// loaded. Reset: synchronous, active high; the cache comes up empty and the RAM contents need no clearing pass.
// ----------------------------------------------------------------------------
module lru_path_key_cache #(
   parameter int CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lpkc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lpkc_pkg::rsp_type rsp_data
);

   // Slot address width and the width of the occupancy count, which must be
   // able to hold CAPACITY itself.
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [AW-1:0] AGE_MAX = AW'(CAPACITY - 1);

   // Occupied slots are always the low indices 0 .. count-1, because a free
   // slot is claimed lowest first and slots are never released. The count
   // therefore stands in for per-slot valid bits. Ages of the occupied slots
   // form a permutation of 0 .. count-1, so when the store is full the oldest
   // slot is the one whose age equals CAPACITY-1.

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_UPDATE,
      ST_FILL,
      ST_DONE
   } state_type;

   state_type                 state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [CW-1:0]             issue_ff, issue_in;
   logic                      pend_ff, pend_in;
   logic [AW-1:0]             pend_addr_ff, pend_addr_in;
   logic [lpkc_pkg::KEY_W-1:0] key_ff, key_in;
   logic                      found_ff, found_in;
   logic                      evict_ff, evict_in;
   logic [AW-1:0]             pick_ff, pick_in;
   logic [AW-1:0]             mine_ff, mine_in;
   logic [AW-1:0]             old_ff, old_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   lpkc_pkg::rsp_type         rsp_ff, rsp_in;

   // RAM ports.
   logic                       key_rd_en, age_rd_en;
   logic [AW-1:0]              rd_addr;
   logic [lpkc_pkg::KEY_W-1:0] key_rdata;
   logic [AW-1:0]              age_rdata;
   logic                       key_wr_en, age_wr_en;
   logic [AW-1:0]              age_wr_addr;
   logic [AW-1:0]              age_wr_data;

   logic issue_live;
   logic last_pend;
   logic hit_now;

   lpkc_ram #(.WIDTH(lpkc_pkg::KEY_W), .DEPTH(CAPACITY)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (pick_ff),
      .wr_data (key_ff),
      .rd_en   (key_rd_en),
      .rd_addr (rd_addr),
      .rd_data (key_rdata)
   );

   lpkc_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_age_ram (
      .clock   (clock),
      .wr_en   (age_wr_en),
      .wr_addr (age_wr_addr),
      .wr_data (age_wr_data),
      .rd_en   (age_rd_en),
      .rd_addr (rd_addr),
      .rd_data (age_rdata)
   );

   // A new request is taken only between items; a finished response may
   // still be waiting in the output register when that happens.
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Both sweeps issue one read per cycle and handle the returned data in the
   // cycle after; the sweep ends when the data for the last occupied slot
   // comes back.
   assign issue_live = (issue_ff < count_ff);
   assign last_pend  = pend_ff && ((CW'(pend_addr_ff) + CW'(1)) == count_ff);
   assign hit_now    = pend_ff && (key_rdata == key_ff);
   assign rd_addr    = issue_ff[AW-1:0];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      key_in       = key_ff;
      found_in     = found_ff;
      evict_in     = evict_ff;
      pick_in      = pick_ff;
      mine_in      = mine_ff;
      old_in       = old_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      key_rd_en    = 1'b0;
      age_rd_en    = 1'b0;
      key_wr_en    = 1'b0;
      age_wr_en    = 1'b0;
      age_wr_addr  = pend_addr_ff;
      age_wr_data  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               key_in   = {req_data.shape_kind, req_data.fill_rule,
                           req_data.content_hash};
               found_in = 1'b0;
               evict_in = 1'b0;
               issue_in = '0;
               if (count_ff == '0) begin
                  // Nothing stored yet: go straight to claiming slot zero.
                  pick_in  = '0;
                  state_in = ST_FILL;
               end else begin
                  state_in = ST_SEARCH;
               end
            end
         end

         ST_SEARCH: begin
            if (issue_live) begin
               key_rd_en    = 1'b1;
               age_rd_en    = 1'b1;
               issue_in     = issue_ff + CW'(1);
               pend_in      = 1'b1;
               pend_addr_in = issue_ff[AW-1:0];
            end
            if (pend_ff) begin
               // The first matching slot wins.
               if (hit_now && !found_ff) begin
                  found_in = 1'b1;
                  pick_in  = pend_addr_ff;
                  mine_in  = age_rdata;
               end
               if (age_rdata == AGE_MAX) begin
                  old_in = pend_addr_ff;
               end
               if (last_pend) begin
                  issue_in = '0;
                  state_in = ST_UPDATE;
                  if (!(found_ff || hit_now)) begin
                     if (count_ff < CW'(CAPACITY)) begin
                        pick_in  = count_ff[AW-1:0];
                        evict_in = 1'b0;
                     end else begin
                        pick_in  = (age_rdata == AGE_MAX) ? pend_addr_ff : old_ff;
                        evict_in = 1'b1;
                     end
                  end
               end
            end
         end

         ST_UPDATE: begin
            if (issue_live) begin
               age_rd_en    = 1'b1;
               issue_in     = issue_ff + CW'(1);
               pend_in      = 1'b1;
               pend_addr_in = issue_ff[AW-1:0];
            end
            if (pend_ff) begin
               // Read-modify-write of one age per cycle. The write trails the
               // read by one slot, so the two never touch the same entry.
               age_wr_en = 1'b1;
               if (pend_addr_ff == pick_ff) begin
                  age_wr_data = '0;
               end else if (!found_ff || (age_rdata < mine_ff)) begin
                  age_wr_data = age_rdata + AW'(1);
               end else begin
                  age_wr_data = age_rdata;
               end
               if (last_pend) begin
                  state_in = found_ff ? ST_DONE : ST_FILL;
               end
            end
         end

         ST_FILL: begin
            // Store the new key and make its slot the most recent.
            key_wr_en   = 1'b1;
            age_wr_en   = 1'b1;
            age_wr_addr = pick_ff;
            age_wr_data = '0;
            if (!evict_ff) begin
               count_in = count_ff + CW'(1);
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_in.hit     = found_ff;
               rsp_in.slot    = lpkc_pkg::SLOT_W'(pick_ff);
               rsp_in.evicted = evict_ff;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      issue_ff     <= issue_in;
      pend_addr_ff <= pend_addr_in;
      key_ff       <= key_in;
      found_ff     <= found_in;
      evict_ff     <= evict_in;
      pick_ff      <= pick_in;
      mine_ff      <= mine_in;
      old_ff       <= old_in;
      rsp_ff       <= rsp_in;
   end

endmodule

FILE: rtl/lpkc_ram.sv
// ----------------------------------------------------------------------------
// lpkc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lpkc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

FILE: rtl/lpkc_checker.sv
// ----------------------------------------------------------------------------
// lpkc_checker
// Port-level checks for the path key cache, bound to the top level.
// ----------------------------------------------------------------------------
module lpkc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input lpkc_pkg::rsp_type rsp_data
);

   // A pending response is not withdrawn while the consumer stalls.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // A hit never reports an eviction.
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.hit && rsp_data.evicted))
      else $error("hit reported together with eviction");

   // A request transfer is followed by a busy period before the next one.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous still in work");

   // Reset leaves no response pending.
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response pending after reset");

endmodule

bind lru_path_key_cache lpkc_checker u_lpkc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

FILE: verif/lru_path_key_cache_tb.sv
// ----------------------------------------------------------------------------
// lru_path_key_cache_tb
// Self-checking testbench for the LRU path key cache. Requests are driven
// from a queue of pending lookups. A behavioral copy of the tag store predicts
// the hit flag, slot and eviction flag of every accepted request. A monitor
// compares each response transfer with the oldest prediction. Both sides
// idle and stall at random in several phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lru_path_key_cache_tb;

   // The block under test is built with the default store size of 64 slots.
   localparam int SLOTS        = 64;
   // Keys that the random part draws from. There are more of them than slots,
   // so lookups mix hits with evictions of the least recent entry.
   localparam int POOL_KEYS    = 100;
   localparam int PHASE_ITEMS  = 105;
   localparam int PHASES       = 5;
   // A full search and age sweep reads every one of the 64 slots twice.
   localparam int DRAIN_CYCLES = 300;
   // The limit allows for the search, age sweep and fill of every item,
   // plus stall and gap time.
   localparam int CYCLE_LIMIT  = 800000;

   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_SENDER,
      MODE_RECEIVER,
      MODE_BOTH
   } idle_mode_type;

   // One pending lookup: the key, the idling mode of its phase, and whether the
   // sender must wait for every outstanding response before presenting it.
   typedef struct {
      lpkc_pkg::req_type key;
      idle_mode_type     mode;
      bit                hold_for_drain;
   } lookup_item_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   lpkc_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   lpkc_pkg::rsp_type rsp_data;

   lookup_item_type   pending_lookups[$];
   lpkc_pkg::rsp_type expected_slots[$];
   idle_mode_type     active_mode = MODE_NONE;
   idle_mode_type     phase_modes[PHASES] =
      '{MODE_NONE, MODE_SENDER, MODE_RECEIVER, MODE_BOTH, MODE_NONE};

   int                total_lookups   = 0;
   int                accepted_count  = 0;
   int                error_count     = 0;
   int                cycle_count     = 0;
   lpkc_pkg::rsp_type oldest_expected;
   bit                send_gap;

   // Shadow copy of the tag store. Ranks count up from 0 for the most recent
   // entry. Entries whose valid bit is clear are never read.
   bit          shadow_valid     [SLOTS] = '{default: 1'b0};
   logic [63:0] shadow_hash      [SLOTS];
   logic [5:0]  shadow_kind_rule [SLOTS];
   int          shadow_rank      [SLOTS];
   int          shadow_occupied  = 0;

   always #1 clock = ~clock;

   lru_path_key_cache #(
      .CAPACITY (SLOTS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   task automatic flag_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic lpkc_pkg::req_type make_key(input int kind, input int rule,
                                                  input logic [63:0] hash);
      lpkc_pkg::req_type k;
      k.shape_kind   = kind[3:0];
      k.fill_rule    = rule[1:0];
      k.content_hash = hash;
      return k;
   endfunction

   function automatic lpkc_pkg::req_type random_key();
      return make_key($urandom_range(15), $urandom_range(3), {$urandom, $urandom});
   endfunction

   // Looks up one key in the shadow store, updates its recency ranks and
   // returns the response that the block must give for it.
   function automatic lpkc_pkg::rsp_type predict_lookup(input lpkc_pkg::req_type k);
      logic [5:0]        kind_rule;
      int                pick;
      int                hit_rank;
      int                oldest;
      bit                found;
      bit                evict;
      lpkc_pkg::rsp_type r;
      kind_rule = {k.shape_kind, k.fill_rule};
      pick      = 0;
      found     = 1'b0;
      evict     = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if (!found && shadow_valid[i] && shadow_hash[i] == k.content_hash &&
             shadow_kind_rule[i] == kind_rule) begin
            pick  = i;
            found = 1'b1;
         end
      end
      if (found) begin
         // Only the entries more recent than the hit one move back a rank.
         hit_rank = shadow_rank[pick];
         for (int i = 0; i < SLOTS; i++) begin
            if (shadow_valid[i] && shadow_rank[i] < hit_rank) begin
               shadow_rank[i]++;
            end
         end
      end else begin
         if (shadow_occupied < SLOTS) begin
            // Claim the lowest free slot.
            pick = -1;
            for (int i = SLOTS - 1; i >= 0; i--) begin
               if (!shadow_valid[i]) begin
                  pick = i;
               end
            end
            shadow_occupied++;
         end else begin
            // Store is full: replace the oldest entry, lowest index on a tie.
            oldest = -1;
            for (int i = 0; i < SLOTS; i++) begin
               if (shadow_valid[i] && shadow_rank[i] > oldest) begin
                  oldest = shadow_rank[i];
                  pick   = i;
               end
            end
            evict = 1'b1;
         end
         for (int i = 0; i < SLOTS; i++) begin
            if (shadow_valid[i]) begin
               shadow_rank[i]++;
            end
         end
         shadow_valid[pick]     = 1'b1;
         shadow_hash[pick]      = k.content_hash;
         shadow_kind_rule[pick] = kind_rule;
      end
      shadow_rank[pick] = 0;
      r.hit     = found;
      r.slot    = pick[5:0];
      r.evicted = evict;
      return r;
   endfunction

   // Request driver. A transfer is recorded and predicted at the edge where it
   // happens. The next pending lookup goes out only when the channel is free,
   // the random gap of its phase allows it, and, for a lookup marked to hold,
   // once no response is outstanding.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_slots.push_back(predict_lookup(req_data));
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_lookups.size() != 0) begin
               send_gap = $urandom_range(99) <
                  (pending_lookups[0].mode == MODE_BOTH   ? 18 :
                   pending_lookups[0].mode == MODE_SENDER ? 51 : 0);
            end
            if (pending_lookups.size() != 0 && !send_gap &&
                !(pending_lookups[0].hold_for_drain && expected_slots.size() != 0)) begin
               req_valid   <= 1'b1;
               req_data    <= pending_lookups[0].key;
               active_mode <= pending_lookups[0].mode;
               pending_lookups.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor. Every response transfer must match the oldest
   // prediction field by field. The stall is redrawn each cycle from the
   // phase of the most recently presented lookup.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_slots.size() == 0) begin
               flag_error($sformatf("unexpected response hit=%0b slot=%0d evicted=%0b",
                                    rsp_data.hit, rsp_data.slot, rsp_data.evicted));
            end else begin
               oldest_expected = expected_slots.pop_front();
               if (rsp_data.hit !== oldest_expected.hit) begin
                  flag_error($sformatf("hit is %0b, expected %0b",
                                       rsp_data.hit, oldest_expected.hit));
               end
               if (rsp_data.slot !== oldest_expected.slot) begin
                  flag_error($sformatf("slot is %0d, expected %0d",
                                       rsp_data.slot, oldest_expected.slot));
               end
               if (rsp_data.evicted !== oldest_expected.evicted) begin
                  flag_error($sformatf("evicted is %0b, expected %0b",
                                       rsp_data.evicted, oldest_expected.evicted));
               end
            end
         end
         rsp_stall <= $urandom_range(99) <
            (active_mode == MODE_BOTH ? 18 : active_mode == MODE_RECEIVER ? 51 : 0);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Watchdog: a hung handshake or a lost response ends the run here.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      lpkc_pkg::req_type key_pool[POOL_KEYS];
      lpkc_pkg::req_type k;
      lookup_item_type   item;
      int                pick_roll;
      int                hot_keys;

      // Directed lookups. They start on an empty store, revisit keys so that
      // an older entry is hit, and present keys that differ from a stored
      // one in only the shape kind, only the fill rule or only the hash.
      item.mode           = MODE_NONE;
      item.hold_for_drain = 1'b0;
      item.key = make_key(0, 0, 64'h0);                  pending_lookups.push_back(item);
      item.key = make_key(15, 3, '1);                    pending_lookups.push_back(item);
      item.key = make_key(0, 0, 64'h0);                  pending_lookups.push_back(item);
      item.key = make_key(0, 1, 64'h0);                  pending_lookups.push_back(item);
      item.key = make_key(1, 0, 64'h0);                  pending_lookups.push_back(item);
      item.key = make_key(0, 0, 64'h1);                  pending_lookups.push_back(item);
      item.key = make_key(15, 3, '1);                    pending_lookups.push_back(item);
      item.key = make_key(8, 2, 64'h8000_0000_0000_0000); pending_lookups.push_back(item);
      item.key = make_key(5, 1, 64'h5555_5555_5555_5555); pending_lookups.push_back(item);
      item.key = make_key(10, 2, 64'hAAAA_AAAA_AAAA_AAAA); pending_lookups.push_back(item);
      item.key = make_key(15, 3, 64'h5555_5555_5555_5555); pending_lookups.push_back(item);
      item.key = make_key(0, 0, 64'h0);                  pending_lookups.push_back(item);
      item.key = make_key(0, 0, 64'h0);                  pending_lookups.push_back(item);
      item.key = make_key(14, 0, '1);                    pending_lookups.push_back(item);
      item.key = make_key(15, 2, '1);                    pending_lookups.push_back(item);
      item.key = make_key(1, 0, 64'h0);                  pending_lookups.push_back(item);
      item.key = make_key(8, 2, 64'h8000_0000_0000_0000); pending_lookups.push_back(item);

      // Pool for the random part. Every fourth key repeats the hash of the one
      // before it with another fill rule or shape kind, as a near miss.
      for (int i = 0; i < POOL_KEYS; i++) begin
         key_pool[i] = random_key();
         if (i % 4 == 3) begin
            key_pool[i] = key_pool[i-1];
            if ($urandom_range(1) == 0) begin
               key_pool[i].fill_rule = key_pool[i-1].fill_rule ^ 2'b01;
            end else begin
               key_pool[i].shape_kind = key_pool[i-1].shape_kind ^ 4'b1000;
            end
         end
      end

      // Random phases. Most lookups come from a hot subset of the pool, which
      // makes hits and reorders recency; the rest come from the whole pool,
      // which overflows the store, or are fresh keys. The first lookup of each
      // phase waits until the block has answered everything before it.
      for (int p = 0; p < PHASES; p++) begin
         hot_keys = (p % 2 == 0) ? 30 : 60;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick_roll = $urandom_range(99);
            if (pick_roll < 10) begin
               k = random_key();
            end else if (pick_roll < 65) begin
               k = key_pool[$urandom_range(hot_keys - 1)];
            end else begin
               k = key_pool[$urandom_range(POOL_KEYS - 1)];
            end
            item.key            = k;
            item.mode           = phase_modes[p];
            item.hold_for_drain = (n == 0);
            pending_lookups.push_back(item);
         end
      end
      total_lookups = pending_lookups.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_lookups || expected_slots.size() != 0) begin
         @(posedge clock);
      end
      // Let any stray response show up before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_slots.size() != 0) begin
         flag_error($sformatf("%0d responses never arrived", expected_slots.size()));
      end
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
